// ----- rtl/ctl_lfu_pkg.sv -----
package ctl_lfu_pkg;

  localparam int ADDR_BITS      = 8;
  localparam int TAG_BITS       = 6;
  localparam int DM_TAG_BITS    = 3;
  localparam int LINE_BITS      = 3;
  localparam int LINES_DEF      = 8;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic MODE_DIRECT = 1'b0;
  localparam logic MODE_ASSOC  = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [LINE_BITS-1:0] sel;
    logic [TAG_BITS-1:0]  key;
  } lkp_t;

  typedef struct packed {
    logic                 fill;
    logic                 bump;
    logic [LINE_BITS-1:0] idx;
  } upd_t;

  typedef struct packed {
    logic                 hit;
    logic [LINE_BITS-1:0] hit_idx;
    logic                 empty;
    logic [LINE_BITS-1:0] empty_idx;
    logic                 min_any;
    logic [LINE_BITS-1:0] min_idx;
  } carry_t;

endpackage

// ----- rtl/ctl_lfu_cell.sv -----
module ctl_lfu_cell #(
  parameter int COUNT_BITS = ctl_lfu_pkg::COUNT_BITS_DEF,
  parameter logic [ctl_lfu_pkg::LINE_BITS-1:0] LINE_ID = '0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_lfu_pkg::lkp_t     lkp,
  input  ctl_lfu_pkg::upd_t     upd,
  input  ctl_lfu_pkg::carry_t   carry_in,
  input  logic [COUNT_BITS-1:0] min_in,
  output ctl_lfu_pkg::carry_t   carry_out,
  output logic [COUNT_BITS-1:0] min_out
);

  logic                               valid_r;
  logic [ctl_lfu_pkg::TAG_BITS-1:0]   tag_r;
  logic [COUNT_BITS-1:0]              count_r;
  ctl_lfu_pkg::carry_t                carry_r, carry_nxt;
  logic [COUNT_BITS-1:0]              min_r, min_nxt;
  logic                               active;
  logic                               match;
  logic                               sel_me;

  assign active = (lkp.mode == ctl_lfu_pkg::MODE_ASSOC) || (lkp.sel == LINE_ID);
  assign match  = valid_r && (tag_r == lkp.key);
  assign sel_me = (upd.idx == LINE_ID);

  always_comb begin
    carry_nxt = carry_in;
    min_nxt   = min_in;
    if (active) begin
      if (!carry_in.hit && match) begin
        carry_nxt.hit     = 1'b1;
        carry_nxt.hit_idx = LINE_ID;
      end
      if (!carry_in.empty && !valid_r) begin
        carry_nxt.empty     = 1'b1;
        carry_nxt.empty_idx = LINE_ID;
      end
      if (!carry_in.min_any || (count_r < min_in)) begin
        carry_nxt.min_any = 1'b1;
        carry_nxt.min_idx = LINE_ID;
        min_nxt           = count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    min_r   <= min_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else if (upd.fill && sel_me) begin
      valid_r <= 1'b1;
      count_r <= COUNT_BITS'(1);
    end else if (upd.bump && sel_me && (count_r != {COUNT_BITS{1'b1}})) begin
      count_r <= count_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (upd.fill && sel_me) begin
      tag_r <= lkp.key;
    end
  end

  assign carry_out = carry_r;
  assign min_out   = min_r;

endmodule

// ----- rtl/cache_tag_lookup_lfu.sv -----
// the address is registered, then the search record passes one cell per cycle
//   down the row of LINES line cells, and the result is registered once the
//   output can take it; a new lookup is taken only after that result is registered
// the next input transfer is taken while the previous result still waits
// reset: synchronous active low, all lines empty, counts zero, direct mapped
module cache_tag_lookup_lfu #(
  parameter int LINES      = ctl_lfu_pkg::LINES_DEF,
  parameter int COUNT_BITS = ctl_lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ctl_lfu_pkg::ADDR_BITS-1:0]    in_byte_address,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit,
  output logic                                 out_replaced,
  output logic [ctl_lfu_pkg::LINE_BITS-1:0]    out_line_used,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_data
);

  localparam int CNT_BITS = $clog2(LINES);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t                               state_r, state_nxt;
  logic [CNT_BITS-1:0]                  cnt_r, cnt_nxt;
  logic                                 mode_r;
  ctl_lfu_pkg::lkp_t                    lkp_r;
  ctl_lfu_pkg::upd_t                    upd;
  ctl_lfu_pkg::carry_t                  carry [LINES];
  logic [COUNT_BITS-1:0]                minc  [LINES];
  ctl_lfu_pkg::carry_t                  last;
  logic                                 in_xfer;
  logic                                 out_xfer;
  logic                                 apply_go;
  logic                                 out_valid_r;
  logic                                 hit_r, repl_r;
  logic [ctl_lfu_pkg::LINE_BITS-1:0]    used_r;
  logic                                 res_hit, res_repl;
  logic [ctl_lfu_pkg::LINE_BITS-1:0]    res_used;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign apply_go  = (state_r == ST_APPLY) && (!out_valid_r || !out_stall);
  assign last      = carry[LINES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ctl_lfu_pkg::MODE_DIRECT;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lkp_r.mode <= mode_r;
      lkp_r.sel  <= in_byte_address[4:2];
      if (mode_r == ctl_lfu_pkg::MODE_ASSOC) begin
        lkp_r.key <= in_byte_address[7:2];
      end else begin
        lkp_r.key <= {{(ctl_lfu_pkg::TAG_BITS - ctl_lfu_pkg::DM_TAG_BITS){1'b0}},
                      in_byte_address[7:5]};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_xfer) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(LINES - 1)) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    res_hit  = 1'b0;
    res_repl = 1'b0;
    res_used = last.min_idx;
    upd.fill = 1'b0;
    upd.bump = 1'b0;
    upd.idx  = last.min_idx;
    if (last.hit) begin
      res_hit  = 1'b1;
      res_used = last.hit_idx;
      upd.bump = apply_go;
      upd.idx  = last.hit_idx;
    end else if (last.empty) begin
      res_used = last.empty_idx;
      upd.fill = apply_go;
      upd.idx  = last.empty_idx;
    end else begin
      res_repl = 1'b1;
      upd.fill = apply_go;
    end
  end

  genvar k;
  generate
    for (k = 0; k < LINES; k++) begin : g_cell
      ctl_lfu_pkg::carry_t   c_in;
      logic [COUNT_BITS-1:0] m_in;
      if (k == 0) begin : g_head
        assign c_in = '0;
        assign m_in = '0;
      end else begin : g_link
        assign c_in = carry[k-1];
        assign m_in = minc[k-1];
      end
      ctl_lfu_cell #(
        .COUNT_BITS (COUNT_BITS),
        .LINE_ID    (ctl_lfu_pkg::LINE_BITS'(k))
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .lkp       (lkp_r),
        .upd       (upd),
        .carry_in  (c_in),
        .min_in    (m_in),
        .carry_out (carry[k]),
        .min_out   (minc[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_go) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      hit_r  <= res_hit;
      repl_r <= res_repl;
      used_r <= res_used;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = hit_r;
  assign out_replaced  = repl_r;
  assign out_line_used = used_r;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int CNT_W      = 4;
  localparam int SEG_ITEMS  = 125;
  localparam int SETTLE     = ctl_lfu_pkg::LINES_DEF + 4;
  localparam int CYCLE_CAP  = 600000;

  typedef struct packed {
    logic                              hit;
    logic                              replaced;
    logic [ctl_lfu_pkg::LINE_BITS-1:0] line;
  } lookup_res_t;

  class lfu_lookup_board;
    bit                               line_ok[ctl_lfu_pkg::LINES_DEF];
    logic [ctl_lfu_pkg::TAG_BITS-1:0] line_key[ctl_lfu_pkg::LINES_DEF];
    logic [CNT_W-1:0]                 line_cnt[ctl_lfu_pkg::LINES_DEF];
    logic                             map_mode;
    lookup_res_t                      pending_lookups[$];
    int                               errors;
    int                               n_checked;
    int                               n_hits;
    int                               n_repl;

    function new();
      for (int k = 0; k < ctl_lfu_pkg::LINES_DEF; k++) begin
        line_ok[k]  = 1'b0;
        line_key[k] = '0;
        line_cnt[k] = '0;
      end
      map_mode  = ctl_lfu_pkg::MODE_DIRECT;
      errors    = 0;
      n_checked = 0;
      n_hits    = 0;
      n_repl    = 0;
    endfunction

    function void set_mode(logic m);
      map_mode = m;
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction

    function void load_line(int k, logic [ctl_lfu_pkg::TAG_BITS-1:0] key);
      line_ok[k]  = 1'b1;
      line_key[k] = key;
      line_cnt[k] = CNT_W'(1);
    endfunction

    function void bump(int k);
      if (line_cnt[k] != '1)
        line_cnt[k] = line_cnt[k] + 1'b1;
    endfunction

    function lookup_res_t predict_lookup(logic [ctl_lfu_pkg::ADDR_BITS-1:0] a);
      lookup_res_t                      r;
      logic [ctl_lfu_pkg::TAG_BITS-1:0] key;
      int                               ln;
      bit                               done;
      r = '0;
      done = 1'b0;
      if (map_mode == ctl_lfu_pkg::MODE_DIRECT) begin
        ln = int'(a[4:2]);
        key = {3'b000, a[7:5]};
        r.line = ctl_lfu_pkg::LINE_BITS'(ln);
        if (!line_ok[ln]) begin
          load_line(ln, key);
        end else if (line_key[ln] == key) begin
          r.hit = 1'b1;
          bump(ln);
        end else begin
          r.replaced = 1'b1;
          load_line(ln, key);
        end
      end else begin
        key = a[7:2];
        for (int k = 0; k < ctl_lfu_pkg::LINES_DEF && !done; k++) begin
          if (line_ok[k] && line_key[k] == key) begin
            r.hit = 1'b1;
            r.line = ctl_lfu_pkg::LINE_BITS'(k);
            bump(k);
            done = 1'b1;
          end
        end
        for (int k = 0; k < ctl_lfu_pkg::LINES_DEF && !done; k++) begin
          if (!line_ok[k]) begin
            r.line = ctl_lfu_pkg::LINE_BITS'(k);
            load_line(k, key);
            done = 1'b1;
          end
        end
        if (!done) begin
          // least used line, lowest index on ties
          ln = 0;
          for (int k = 1; k < ctl_lfu_pkg::LINES_DEF; k++)
            if (line_cnt[k] < line_cnt[ln])
              ln = k;
          r.line = ctl_lfu_pkg::LINE_BITS'(ln);
          r.replaced = 1'b1;
          load_line(ln, key);
        end
      end
      return r;
    endfunction

    function void take_address(logic [ctl_lfu_pkg::ADDR_BITS-1:0] a);
      pending_lookups.push_back(predict_lookup(a));
    endfunction

    task flag(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task match_result(logic hit, logic replaced, logic [ctl_lfu_pkg::LINE_BITS-1:0] line);
      lookup_res_t want;
      if (pending_lookups.size() == 0) begin
        flag($sformatf("result hit=%0b replaced=%0b line=%0d with nothing outstanding",
                       hit, replaced, line));
      end else begin
        want = pending_lookups.pop_front();
        n_checked++;
        if (want.hit) n_hits++;
        if (want.replaced) n_repl++;
        if (hit !== want.hit)
          flag($sformatf("hit %0b, want %0b", hit, want.hit));
        if (replaced !== want.replaced)
          flag($sformatf("replaced %0b, want %0b", replaced, want.replaced));
        if (line !== want.line)
          flag($sformatf("line_used %0d, want %0d", line, want.line));
      end
    endtask
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [ctl_lfu_pkg::ADDR_BITS-1:0] in_byte_address = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              out_hit;
  logic                              out_replaced;
  logic [ctl_lfu_pkg::LINE_BITS-1:0] out_line_used;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic                              cfg_data = 1'b0;

  lfu_lookup_board board;
  int              send_gap_pct = 0;
  int              out_stall_pct = 0;
  int              cycles = 0;
  int              mode_writes = 0;
  logic [2:0]      hot_tag = '0;
  logic [5:0]      hot_base = '0;

  cache_tag_lookup_lfu #(.COUNT_BITS(CNT_W)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_address (in_byte_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_replaced    (out_replaced),
    .out_line_used   (out_line_used),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // result transfer
  always @(posedge clk) begin
    if (rst_n && board != null && out_valid && !out_stall)
      board.match_result(out_hit, out_replaced, out_line_used);
  end

  task send_address(logic [ctl_lfu_pkg::ADDR_BITS-1:0] a);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_byte_address <= ctl_lfu_pkg::ADDR_BITS'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_address <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_address(a);
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_mode(logic m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_mode(m);
    mode_writes++;
    cfg_valid <= 1'b0;
  endtask

  function logic [ctl_lfu_pkg::ADDR_BITS-1:0] pick_address(logic m);
    int   idx;
    logic [5:0] key;
    if ($urandom_range(99) < 25)
      return ctl_lfu_pkg::ADDR_BITS'($urandom_range(255));
    if (m == ctl_lfu_pkg::MODE_DIRECT)
      return {hot_tag ^ 3'($urandom_range(1)), 3'($urandom_range(7)), 2'($urandom_range(3))};
    // skewed pool of eleven tags so counts differ and saturate
    idx = $urandom_range(10) & $urandom_range(10);
    key = hot_base + 6'(idx);
    return {key, 2'($urandom_range(3))};
  endfunction

  initial begin
    logic [ctl_lfu_pkg::ADDR_BITS-1:0] dm_list[$];
    logic [ctl_lfu_pkg::ADDR_BITS-1:0] fa_list[$];
    logic                              m;
    board = new();
    dm_list = '{8'h00, 8'h03, 8'hFF, 8'hFE, 8'hE3, 8'h01};
    fa_list = '{8'h02, 8'h1F, 8'hFC, 8'h04, 8'h08, 8'h0C, 8'h10, 8'h14,
                8'hFD, 8'h80, 8'h84, 8'hF0, 8'h00, 8'h1C};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 20;
    out_stall_pct = 68;
    write_mode(ctl_lfu_pkg::MODE_DIRECT);
    foreach (dm_list[i]) send_address(dm_list[i]);
    drain();
    // tags written in direct mode stay visible to the associative search
    write_mode(ctl_lfu_pkg::MODE_ASSOC);
    foreach (fa_list[i]) send_address(fa_list[i]);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_gap_pct = 20; out_stall_pct = 68; end
        1: begin send_gap_pct = 68; out_stall_pct = 20; end
        default: begin send_gap_pct = 0; out_stall_pct = 0; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        m = ((seg + phase) % 2 == 0) ? ctl_lfu_pkg::MODE_DIRECT : ctl_lfu_pkg::MODE_ASSOC;
        hot_tag = 3'($urandom_range(7));
        hot_base = 6'($urandom_range(63));
        drain();
        write_mode(m);
        for (int n = 0; n < SEG_ITEMS; n++) begin
          send_address(pick_address(m));
          if ($urandom_range(199) == 0) drain();
        end
      end
    end
    drain();

    $display("checked %0d lookups: %0d hits, %0d evictions, %0d mode writes",
             board.n_checked, board.n_hits, board.n_repl, mode_writes);
    $display("both mappings, shared tags across mode changes, 4-bit saturating counts");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", board.errors, board.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
